// ===== rtl/tsst_pkg.sv =====
package tsst_pkg;

  // Field widths of the item and result channels.
  localparam int TIME_W = 31;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 7;
  localparam int SIDX_W = 6;
  localparam int ST_W   = 2;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EXISTS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // Scan token that travels down the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] lo;    // range begin, zero taken as one
    logic [TIME_W-1:0] hi;    // range end (an add uses its begin), zero taken as one
    logic [TIME_W-1:0] ta;    // raw begin or add time
    logic [TIME_W-1:0] tb;    // raw end
    logic              hit;   // add: time exists; read: a slot was chosen
    logic              free;  // add: a free slot was seen
    logic [TIME_W-1:0] mn;    // read: best time; status: minimum
    logic [TIME_W-1:0] mx;    // status: maximum
    logic [CNT_W-1:0]  cnt;   // status and clean: in-range count
  } tok_t;

  // Table write controls broadcast to every cell.
  typedef struct packed {
    logic              en;    // write data into the addressed slot
    logic              clr;   // free every slot
    logic [TIME_W-1:0] data;
  } wr_t;

endpackage

// ===== rtl/tsst_cell.sv =====
module tsst_cell #(
  parameter int IDX_W = 6,
  parameter int POS   = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tsst_pkg::CNT_W-1:0] scan_n,
  input  tsst_pkg::tok_t            tok_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  tsst_pkg::wr_t             wr_i,
  input  logic [IDX_W-1:0]          wr_idx,
  output tsst_pkg::tok_t            tok_o,
  output logic [IDX_W-1:0]          idx_o
);
  import tsst_pkg::*;

  logic [TIME_W-1:0] slot_r, slot_nxt;
  tok_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              active;
  logic              inr;
  logic              take;

  // This slot takes part only when it lies below the scan length.
  assign active = 32'(scan_n) > 32'(POS);
  assign inr    = (slot_r >= tok_i.lo) && (slot_r <= tok_i.hi);
  assign take   = tok_i.valid && active;

  // Fold this slot into the passing token.
  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (take) begin
      case (tok_i.kind)
        KIND_ADD: begin
          if (slot_r == '0) begin
            tok_nxt.free = 1'b1;
            idx_nxt      = IDX_W'(POS);
          end else if (inr) begin
            tok_nxt.hit = 1'b1;
          end
        end
        KIND_READ: begin
          if (inr && (!tok_i.hit || slot_r < tok_i.mn)) begin
            tok_nxt.hit = 1'b1;
            tok_nxt.mn  = slot_r;
            idx_nxt     = IDX_W'(POS);
          end
        end
        KIND_STATUS: begin
          if (inr) begin
            tok_nxt.cnt = tok_i.cnt + 1'b1;
            if (slot_r < tok_i.mn) begin
              tok_nxt.mn = slot_r;
            end
            if (slot_r > tok_i.mx) begin
              tok_nxt.mx = slot_r;
            end
          end
        end
        KIND_CLEAN: begin
          if (inr) begin
            tok_nxt.cnt = tok_i.cnt + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot contents: clear all, addressed write, or clean as the token passes.
  always_comb begin
    slot_nxt = slot_r;
    if (wr_i.clr) begin
      slot_nxt = '0;
    end else if (wr_i.en && wr_idx == IDX_W'(POS)) begin
      slot_nxt = wr_i.data;
    end else if (take && tok_i.kind == KIND_CLEAN && inr) begin
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      tok_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // The chosen slot index moves with the token without reset.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ===== rtl/timestamp_slot_table.sv =====
// Timestamp slot table. Each slot holds a 31-bit time; zero marks a free slot.
// Input channel in_*: in_tuser carries the operation (add, read nearest,
// status, clean range, reset all), in_tdata the begin/add time and the end
// time. Every item gives exactly one result item on out_*.
// The cfg port sets how many slots, from slot 0 up, each operation scans.
// The table is a row of SLOTS cells, one slot per cell. An operation travels
// down the row as a token that visits one cell per cycle, from a launch
// register through every cell register, and its result is then registered
// in the output register. One item is in the row at a time: the next item
// is taken only after the token of the last one leaves the row.
// An add writes its chosen slot when the token leaves the last cell.
// A finished result sits in the output register, and a second one may wait in
// a holding register, so a stalled receiver does not block the next item;
// in_tready is low while an item is in the row and while the holding register
// is full.
// Synchronous reset frees every slot, sets the scan length to 64 and drops
// all pending items and results.
module timestamp_slot_table #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: scan length.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // time_a[30:0], time_b[61:31], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // status[1:0], found[2], slot_index[8:3],
                                  // item_count[15:9], first_time[46:16],
                                  // last_time[77:47], zero pad
);
  import tsst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OUT_W = 80;

  logic [CNT_W-1:0]  scan_r;
  logic              busy_r;
  tok_t              launch_r, launch_nxt;
  logic              out_v_r, hold_v_r;
  logic [OUT_W-1:0]  out_d_r, hold_d_r;
  logic [OUT_W-1:0]  res;
  logic              in_acc, out_take, fin;
  wr_t               wr;
  logic [IDX_W-1:0]  wr_idx;

  tok_t              tok_w [0:SLOTS];
  logic [IDX_W-1:0]  idx_w [0:SLOTS];

  logic [TIME_W-1:0] ta, tb, lo;
  logic [ST_W-1:0]   r_st;
  logic              r_found;
  logic [SIDX_W-1:0] r_idx;
  logic [CNT_W-1:0]  r_cnt;
  logic [TIME_W-1:0] r_first, r_last;
  tok_t              fin_tok;
  logic [IDX_W-1:0]  fin_idx;

  assign in_tready = !busy_r && !hold_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_v_r && out_tready;

  // Build the scan token for an accepted item.
  assign ta = in_tdata[TIME_W-1:0];
  assign tb = in_tdata[2*TIME_W-1:TIME_W];
  assign lo = (ta == '0) ? TIME_W'(1) : ta;

  always_comb begin
    launch_nxt       = launch_r;
    launch_nxt.valid = in_acc;
    if (in_acc) begin
      launch_nxt.kind = in_tuser;
      launch_nxt.lo   = lo;
      if (in_tuser == KIND_ADD) begin
        launch_nxt.hi = lo;
      end else begin
        launch_nxt.hi = (tb == '0) ? TIME_W'(1) : tb;
      end
      launch_nxt.ta   = ta;
      launch_nxt.tb   = tb;
      launch_nxt.hit  = 1'b0;
      launch_nxt.free = 1'b0;
      launch_nxt.mn   = tb;
      launch_nxt.mx   = ta;
      launch_nxt.cnt  = '0;
    end
  end

  // Scan length register and item control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= CNT_W'(64);
      busy_r   <= 1'b0;
      launch_r <= '0;
    end else begin
      if (cfg_we) begin
        scan_r <= cfg_wdata;
      end
      launch_r <= launch_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Row of slot cells.
  assign tok_w[0] = launch_r;
  assign idx_w[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tsst_cell #(
      .IDX_W (IDX_W),
      .POS   (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .scan_n (scan_r),
      .tok_i  (tok_w[g]),
      .idx_i  (idx_w[g]),
      .wr_i   (wr),
      .wr_idx (wr_idx),
      .tok_o  (tok_w[g+1]),
      .idx_o  (idx_w[g+1])
    );
  end

  assign fin_tok = tok_w[SLOTS];
  assign fin_idx = idx_w[SLOTS];
  assign fin     = fin_tok.valid;

  // Finish the operation when the token leaves the last cell.
  always_comb begin
    r_st    = ST_OK;
    r_found = 1'b0;
    r_idx   = '0;
    r_cnt   = '0;
    r_first = '0;
    r_last  = '0;
    wr.en   = 1'b0;
    wr.clr  = 1'b0;
    wr.data = fin_tok.ta;
    wr_idx  = fin_idx;
    if (fin) begin
      case (fin_tok.kind)
        KIND_ADD: begin
          if (fin_tok.hit) begin
            r_st = ST_EXISTS;
          end else if (fin_tok.free) begin
            wr.en = 1'b1;
            r_idx = SIDX_W'(fin_idx);
          end else begin
            r_st = ST_FULL;
          end
        end
        KIND_READ: begin
          if (fin_tok.hit) begin
            r_found = 1'b1;
            r_idx   = SIDX_W'(fin_idx);
            r_first = fin_tok.mn;
          end
        end
        KIND_STATUS: begin
          r_cnt = fin_tok.cnt;
          if (fin_tok.cnt != '0) begin
            r_first = fin_tok.mn;
            r_last  = fin_tok.mx;
          end else begin
            r_first = fin_tok.ta;
            r_last  = fin_tok.tb;
          end
        end
        KIND_CLEAN: begin
          r_cnt = fin_tok.cnt;
        end
        KIND_RESET: begin
          wr.clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res = {2'b00, r_last, r_first, r_cnt, r_idx, r_found, r_st};

  // Output register with one holding stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if (fin) begin
        if (!out_v_r || out_take) begin
          out_v_r <= 1'b1;
        end else begin
          hold_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r  <= hold_v_r;
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (!out_v_r || out_take) begin
        out_d_r <= res;
      end else begin
        hold_d_r <= res;
      end
    end else if (out_take && hold_v_r) begin
      out_d_r <= hold_d_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
